// File: rtl/core/cube_map_face_select_uv_macros.svh
// Assertion macros for the cube map face select block.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef CUBE_MAP_FACE_SELECT_UV_MACROS_SVH
`define CUBE_MAP_FACE_SELECT_UV_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define CMFS_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define CMFS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define CMFS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/cmfs_pkg.sv
// Shared types and constants for the cube map face select block.
// No dependencies; imported by the top level and the divider pipeline.
package cmfs_pkg;

  localparam int IN_BITS_DEF   = 16;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [2:0] {
    FACE_POS_X = 3'd0,
    FACE_NEG_X = 3'd1,
    FACE_POS_Y = 3'd2,
    FACE_NEG_Y = 3'd3,
    FACE_POS_Z = 3'd4,
    FACE_NEG_Z = 3'd5
  } face_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  typedef struct packed {
    face_t face;
    logic  deg;
    logic  neg_u;
    logic  neg_v;
  } side_t;

endpackage

// File: rtl/core/cmfs_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Computes floor(dividend * 2^(FRAC_BITS-1) / divisor) for dividend <= divisor.
// Uses cmfs_pkg for parameter defaults.
module cmfs_div #(
  parameter int IN_BITS   = cmfs_pkg::IN_BITS_DEF,
  parameter int FRAC_BITS = cmfs_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [IN_BITS-1:0]   dividend,
  input  logic [IN_BITS-1:0]   divisor,
  output logic [FRAC_BITS-1:0] quot
);
  import cmfs_pkg::*;

  logic [IN_BITS-1:0]   rem [FRAC_BITS];
  logic [IN_BITS-1:0]   dvs [FRAC_BITS];
  logic [FRAC_BITS-1:0] qt  [FRAC_BITS];

  for (genvar k = 0; k < FRAC_BITS; k++) begin : g_stage
    logic [IN_BITS:0]     trial;
    logic [IN_BITS:0]     diff;
    logic [IN_BITS-1:0]   dv_in;
    logic [FRAC_BITS-1:0] q_in;
    logic                 ge;

    if (k == 0) begin : g_first
      assign trial = {1'b0, dividend};
      assign dv_in = divisor;
      assign q_in  = '0;
    end else begin : g_rest
      assign trial = {rem[k-1], 1'b0};
      assign dv_in = dvs[k-1];
      assign q_in  = qt[k-1];
    end

    assign ge   = trial >= {1'b0, dv_in};
    assign diff = trial - {1'b0, dv_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[IN_BITS-1:0] : trial[IN_BITS-1:0];
        dvs[k] <= dv_in;
        qt[k]  <= q_in | (ge ? (FRAC_BITS'(1) << (FRAC_BITS - 1 - k)) : '0);
      end
    end
  end

  assign quot = qt[FRAC_BITS-1];

endmodule

// File: rtl/core/cube_map_face_select_uv.sv
// Cube map face select and face coordinate projection, top level.
// Pipeline stages: magnitude stage, axis select stage, one divider stage per quotient bit,
// output stage. Throughput one beat per cycle while the result is not stalled.
// A result stall while res_valid is high freezes the whole pipeline; no beat is lost or repeated.
// Synchronous active-high reset clears valid bits only; payload registers are not reset.
// Depends on cmfs_pkg, cmfs_div and cube_map_face_select_uv_macros.svh.
`include "cube_map_face_select_uv_macros.svh"

module cube_map_face_select_uv #(
  parameter int IN_BITS   = cmfs_pkg::IN_BITS_DEF,
  parameter int FRAC_BITS = cmfs_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        dir_valid,
  output logic                        dir_stall,
  input  logic signed [IN_BITS-1:0]   dir_x,
  input  logic signed [IN_BITS-1:0]   dir_y,
  input  logic signed [IN_BITS-1:0]   dir_z,
  output logic                        res_valid,
  input  logic                        res_stall,
  output logic [2:0]                  face,
  output logic [FRAC_BITS:0]          coord_u,
  output logic [FRAC_BITS:0]          coord_v,
  output logic                        degenerate
);
  import cmfs_pkg::*;

  localparam logic [FRAC_BITS:0] HALF = (FRAC_BITS+1)'(1) << (FRAC_BITS - 1);
  localparam logic [FRAC_BITS:0] ONE  = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic en;

  // magnitude stage
  logic               s1_vld;
  logic [IN_BITS-1:0] s1_mx, s1_my, s1_mz;
  logic               s1_nx, s1_ny, s1_nz;

  // axis select stage
  logic               s2_vld;
  logic [IN_BITS-1:0] s2_major, s2_umag, s2_vmag;
  side_t              s2_side;

  axis_t              axis;
  logic [IN_BITS-1:0] major_next, umag_next, vmag_next;
  side_t              side_next;

  // divider stages
  logic               dv_vld  [FRAC_BITS];
  side_t              dv_side [FRAC_BITS];
  logic [FRAC_BITS-1:0] q_u, q_v;

  // output stage
  logic [FRAC_BITS:0] u_next, v_next;

  assign dir_stall = res_valid && res_stall;
  assign en        = !dir_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (en) begin
      s1_vld <= dir_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_nx <= dir_x[IN_BITS-1];
      s1_ny <= dir_y[IN_BITS-1];
      s1_nz <= dir_z[IN_BITS-1];
      s1_mx <= dir_x[IN_BITS-1] ? IN_BITS'(-dir_x) : IN_BITS'(dir_x);
      s1_my <= dir_y[IN_BITS-1] ? IN_BITS'(-dir_y) : IN_BITS'(dir_y);
      s1_mz <= dir_z[IN_BITS-1] ? IN_BITS'(-dir_z) : IN_BITS'(dir_z);
    end
  end

  always_comb begin
    axis       = AXIS_X;
    major_next = s1_mx;
    if (s1_my > major_next) begin
      axis       = AXIS_Y;
      major_next = s1_my;
    end
    if (s1_mz > major_next) begin
      axis       = AXIS_Z;
      major_next = s1_mz;
    end
  end

  always_comb begin
    side_next.deg = (major_next == '0);
    case (axis)
      AXIS_X: begin
        side_next.face  = s1_nx ? FACE_NEG_X : FACE_POS_X;
        umag_next       = s1_mz;
        vmag_next       = s1_my;
        side_next.neg_u = s1_nz ^ s1_nx;
        side_next.neg_v = s1_ny;
      end
      AXIS_Y: begin
        side_next.face  = s1_ny ? FACE_NEG_Y : FACE_POS_Y;
        umag_next       = s1_mx;
        vmag_next       = s1_mz;
        side_next.neg_u = s1_nx;
        side_next.neg_v = s1_nz ^ s1_ny;
      end
      AXIS_Z: begin
        side_next.face  = s1_nz ? FACE_NEG_Z : FACE_POS_Z;
        umag_next       = s1_mx;
        vmag_next       = s1_my;
        side_next.neg_u = s1_nx ^ ~s1_nz;
        side_next.neg_v = s1_ny;
      end
      default: begin
        side_next.face  = FACE_POS_X;
        umag_next       = s1_mz;
        vmag_next       = s1_my;
        side_next.neg_u = s1_nz;
        side_next.neg_v = s1_ny;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (en) begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_major <= major_next;
      s2_umag  <= umag_next;
      s2_vmag  <= vmag_next;
      s2_side  <= side_next;
    end
  end

  cmfs_div #(
    .IN_BITS   (IN_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div_u (
    .clk      (clk),
    .en       (en),
    .dividend (s2_umag),
    .divisor  (s2_major),
    .quot     (q_u)
  );

  cmfs_div #(
    .IN_BITS   (IN_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div_v (
    .clk      (clk),
    .en       (en),
    .dividend (s2_vmag),
    .divisor  (s2_major),
    .quot     (q_v)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < FRAC_BITS; k++) begin
        dv_vld[k] <= 1'b0;
      end
    end else if (en) begin
      dv_vld[0] <= s2_vld;
      for (int k = 1; k < FRAC_BITS; k++) begin
        dv_vld[k] <= dv_vld[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_side[0] <= s2_side;
      for (int k = 1; k < FRAC_BITS; k++) begin
        dv_side[k] <= dv_side[k-1];
      end
    end
  end

  always_comb begin
    if (dv_side[FRAC_BITS-1].deg) begin
      u_next = HALF;
      v_next = HALF;
    end else begin
      u_next = dv_side[FRAC_BITS-1].neg_u ? HALF - {1'b0, q_u} : HALF + {1'b0, q_u};
      v_next = dv_side[FRAC_BITS-1].neg_v ? HALF - {1'b0, q_v} : HALF + {1'b0, q_v};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= dv_vld[FRAC_BITS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      face       <= dv_side[FRAC_BITS-1].face;
      degenerate <= dv_side[FRAC_BITS-1].deg;
      coord_u    <= u_next;
      coord_v    <= v_next;
    end
  end

  `CMFS_ASSERT_SAME(a_deg_center, clk, rst, res_valid && degenerate, face == FACE_POS_X && coord_u == HALF && coord_v == HALF, "degenerate beat not centered on face 0")
  `CMFS_ASSERT_SAME(a_face_range, clk, rst, res_valid, face == FACE_POS_X || face == FACE_NEG_X || face == FACE_POS_Y || face == FACE_NEG_Y || face == FACE_POS_Z || face == FACE_NEG_Z, "face code out of range")
  `CMFS_ASSERT_SAME(a_coord_range, clk, rst, res_valid, coord_u <= ONE && coord_v <= ONE, "face coordinate above 1.0")
  `CMFS_ASSERT_NEXT(a_accept_enters, clk, rst, dir_valid && !dir_stall, s1_vld, "accepted beat did not enter the pipeline")

endmodule

// File: tb/tb.sv
// Self-checking bench for cube_map_face_select_uv: directed and random direction vectors,
// with a scoreboard that predicts face, u, v and the zero-vector flag for each beat.
// Depends on cmfs_pkg and the RTL top level only.
module tb;
  import cmfs_pkg::*;

  localparam int IN_W = IN_BITS_DEF;
  localparam int FW = FRAC_BITS_DEF;
  localparam longint unsigned HALF = 64'd1 << (FW - 1);
  localparam longint unsigned ONE = 64'd1 << FW;
  localparam int LATENCY = FW + 3;
  localparam int N_RANDOM = 1250;
  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT = 28;

  class face_lookup_board;
    typedef struct {
      face_t          face;
      logic [FW:0]    u;
      logic [FW:0]    v;
      logic           deg;
    } lookup_t;

    lookup_t pending_lookups[$];
    int errors = 0;

    function automatic lookup_t project_dir(logic [IN_W-1:0] x, logic [IN_W-1:0] y,
                                            logic [IN_W-1:0] z);
      logic [IN_W-1:0] raw[3];
      logic [IN_W-1:0] flipped;
      longint unsigned mag[3];
      longint unsigned p[3];
      longint unsigned major;
      longint unsigned q;
      bit neg[3];
      axis_t ax;
      lookup_t r;
      raw[0] = x;
      raw[1] = y;
      raw[2] = z;
      for (int i = 0; i < 3; i++) begin
        neg[i] = raw[i][IN_W-1];
        flipped = -raw[i];
        mag[i] = 64'(neg[i] ? flipped : raw[i]);
      end
      ax = AXIS_X;
      major = mag[0];
      if (mag[1] > major) begin
        ax = AXIS_Y;
        major = mag[1];
      end
      if (mag[2] > major) begin
        ax = AXIS_Z;
        major = mag[2];
      end
      if (major == 0) begin
        r.face = FACE_POS_X;
        r.u = (FW+1)'(HALF);
        r.v = (FW+1)'(HALF);
        r.deg = 1'b1;
        return r;
      end
      for (int i = 0; i < 3; i++) begin
        q = (mag[i] << (FW - 1)) / major;
        if (q > HALF) q = HALF;
        p[i] = neg[i] ? HALF - q : HALF + q;
      end
      case (ax)
        AXIS_X: r.face = neg[0] ? FACE_NEG_X : FACE_POS_X;
        AXIS_Y: r.face = neg[1] ? FACE_NEG_Y : FACE_POS_Y;
        default: r.face = neg[2] ? FACE_NEG_Z : FACE_POS_Z;
      endcase
      case (r.face)
        FACE_POS_X: begin r.u = (FW+1)'(p[2]);       r.v = (FW+1)'(p[1]);       end
        FACE_NEG_X: begin r.u = (FW+1)'(ONE - p[2]); r.v = (FW+1)'(p[1]);       end
        FACE_POS_Y: begin r.u = (FW+1)'(p[0]);       r.v = (FW+1)'(p[2]);       end
        FACE_NEG_Y: begin r.u = (FW+1)'(p[0]);       r.v = (FW+1)'(ONE - p[2]); end
        FACE_POS_Z: begin r.u = (FW+1)'(ONE - p[0]); r.v = (FW+1)'(p[1]);       end
        default:    begin r.u = (FW+1)'(p[0]);       r.v = (FW+1)'(p[1]);       end
      endcase
      r.deg = 1'b0;
      return r;
    endfunction

    function void note_dir(logic [IN_W-1:0] x, logic [IN_W-1:0] y, logic [IN_W-1:0] z);
      pending_lookups.insert(pending_lookups.size(), project_dir(x, y, z));
    endfunction

    function void check_lookup(logic [2:0] f, logic [FW:0] u, logic [FW:0] v, logic d);
      lookup_t e;
      if (pending_lookups.size() == 0) begin
        $display("%0t: unexpected result face %0d u %0d v %0d degenerate %0b",
                 $time, f, u, v, d);
        errors++;
        return;
      end
      e = pending_lookups.pop_front();
      if (f !== e.face) begin
        $display("%0t: face expected %0d actual %0d", $time, e.face, f);
        errors++;
      end
      if (u !== e.u) begin
        $display("%0t: coord_u expected %0d actual %0d", $time, e.u, u);
        errors++;
      end
      if (v !== e.v) begin
        $display("%0t: coord_v expected %0d actual %0d", $time, e.v, v);
        errors++;
      end
      if (d !== e.deg) begin
        $display("%0t: degenerate expected %0b actual %0b", $time, e.deg, d);
        errors++;
      end
    endfunction

    function int pending();
      return pending_lookups.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  logic dir_valid;
  logic dir_stall;
  logic [IN_W-1:0] dir_x;
  logic [IN_W-1:0] dir_y;
  logic [IN_W-1:0] dir_z;
  logic res_valid;
  logic res_stall;
  logic [2:0] face;
  logic [FW:0] coord_u;
  logic [FW:0] coord_v;
  logic degenerate;

  bit no_gaps = 1'b0;
  int cycle_count = 0;
  face_lookup_board board = new();

  cube_map_face_select_uv u_top (
    .clk(clk),
    .rst(rst),
    .dir_valid(dir_valid),
    .dir_stall(dir_stall),
    .dir_x(dir_x),
    .dir_y(dir_y),
    .dir_z(dir_z),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .face(face),
    .coord_u(coord_u),
    .coord_v(coord_v),
    .degenerate(degenerate)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && dir_valid && !dir_stall) board.note_dir(dir_x, dir_y, dir_z);
    if (!rst && res_valid && !res_stall) board.check_lookup(face, coord_u, coord_v, degenerate);
  end

  always @(negedge clk) begin
    res_stall <= !no_gaps && ($urandom_range(99) < IDLE_PCT);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("status: fail");
    $finish;
  end

  function automatic logic [IN_W-1:0] with_sign(longint unsigned m, bit n);
    logic [IN_W-1:0] t;
    t = IN_W'(m);
    return n ? -t : t;
  endfunction

  function automatic logic [IN_W-1:0] rand_signed_upto(longint unsigned m);
    bit n;
    n = 1'($urandom_range(1));
    return with_sign(64'($urandom_range(0, 32'(m))), n);
  endfunction

  function automatic logic [IN_W-1:0] pick_extreme();
    case ($urandom_range(4))
      0: return '0;
      1: return IN_W'(1);
      2: return '1;
      3: return {1'b0, {(IN_W-1){1'b1}}};
      default: return {1'b1, {(IN_W-1){1'b0}}};
    endcase
  endfunction

  task automatic send_dir(input logic [IN_W-1:0] x, input logic [IN_W-1:0] y,
                          input logic [IN_W-1:0] z);
    while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
      dir_valid <= 1'b0;
      @(negedge clk);
    end
    dir_valid <= 1'b1;
    dir_x <= x;
    dir_y <= y;
    dir_z <= z;
    @(posedge clk);
    while (dir_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [IN_W-1:0] c[3];
    logic [IN_W-1:0] maxp;
    logic [IN_W-1:0] maxn;
    longint unsigned m;
    bit n;
    int ax;
    maxp = {1'b0, {(IN_W-1){1'b1}}};
    maxn = {1'b1, {(IN_W-1){1'b0}}};
    rst = 1'b1;
    dir_valid = 1'b0;
    dir_x = '0;
    dir_y = '0;
    dir_z = '0;
    res_stall = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_dir(0, 0, 0);
    send_dir(100, 20, -30);
    send_dir(-100, 20, -30);
    send_dir(20, 100, -30);
    send_dir(20, -100, -30);
    send_dir(20, -30, 100);
    send_dir(20, -30, -100);
    send_dir(50, 50, 10);
    send_dir(-50, 50, 50);
    send_dir(3, -70, 70);
    send_dir(-9, -9, -9);
    send_dir(maxn, 0, 0);
    send_dir(0, maxn, maxp);
    send_dir(maxp, maxp, maxn);
    send_dir(maxn, maxn, maxn);
    send_dir(maxp, maxp, maxp);
    send_dir(maxn, maxp, maxn);
    send_dir(1, 0, 0);
    send_dir(0, 0, -1);
    send_dir(0, 1, 0);
    send_dir(7, -7, 7);
    send_dir(maxp, -1, 1);
    send_dir(1, maxn, -1);

    for (int i = 0; i < N_RANDOM; i++) begin
      no_gaps = (i >= 500 && i < 800);
      case ($urandom_range(9))
        0, 1, 2, 9: begin
          for (int k = 0; k < 3; k++) c[k] = IN_W'($urandom);
        end
        3, 4: begin
          for (int k = 0; k < 3; k++) begin
            c[k] = with_sign(64'($urandom_range(0, 8)), 1'($urandom_range(1)));
          end
        end
        5, 6: begin
          ax = int'($urandom_range(2));
          n = 1'($urandom_range(1));
          m = 64'($urandom_range(1, 32'(n ? (64'd1 << (IN_W - 1))
                                            : (64'd1 << (IN_W - 1)) - 1)));
          for (int k = 0; k < 3; k++) c[k] = rand_signed_upto(m);
          c[ax] = with_sign(m, n);
        end
        7: begin
          m = 64'($urandom_range(1, 32'((64'd1 << (IN_W - 1)) - 1)));
          for (int k = 0; k < 3; k++) c[k] = with_sign(m, 1'($urandom_range(1)));
          if ($urandom_range(1) != 0) c[$urandom_range(2)] = rand_signed_upto(m);
        end
        default: begin
          for (int k = 0; k < 3; k++) c[k] = pick_extreme();
        end
      endcase
      send_dir(c[0], c[1], c[2]);
    end
    no_gaps = 1'b0;
    dir_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (board.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/cmfs_pkg.sv
rtl/core/cmfs_div.sv
rtl/core/cube_map_face_select_uv.sv
tb/tb.sv
